// ===== rtl/sbusr_pkg.sv =====
package sbusr_pkg;

	localparam int FRAME_LEN          = 25;
	localparam int ANALOG_CHANS       = 16;
	localparam int CHAN_COUNT         = 18;
	localparam int CHAN_BITS          = 11;
	localparam int ANALOG_BYTES       = 22;
	localparam int ANALOG_BITS        = ANALOG_BYTES * 8;
	localparam int FLAG_BYTE          = 23;
	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [7:0]  START_BYTE = 8'h0F;
	localparam logic [10:0] DIG_LOW    = 11'd172;
	localparam logic [10:0] DIG_HIGH   = 11'd1812;

	localparam logic [7:0] BIT_CH17 = 8'b0000_0001;
	localparam logic [7:0] BIT_CH18 = 8'b0000_0010;
	localparam logic [7:0] BIT_LOSS = 8'b0000_0100;
	localparam logic [7:0] BIT_FAIL = 8'b0000_1000;

	localparam logic [31:0] SYNC_GAP_RESET = 32'd3000;
	localparam logic [31:0] FAILSAFE_RESET = 32'd100000;

	localparam logic [2:0] ADDR_SYNC_GAP = 3'd0;
	localparam logic [2:0] ADDR_FAILSAFE = 3'd4;

	// One decoded-to-be frame handed from the byte front end to the channel emitter.
	typedef struct packed {
		logic                   lost;
		logic [7:0]             flags;
		logic [ANALOG_BITS-1:0] analog;
	} frame_entry_t;

endpackage

// ===== rtl/sbusr_front.sv =====
module sbusr_front
	import sbusr_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   rx_byte,
	input  logic [31:0]  now_us,
	input  logic         rx_error,
	input  logic [31:0]  sync_gap_us,
	input  logic [31:0]  failsafe_us,
	output logic         push,
	output frame_entry_t push_entry,
	input  logic         queue_full
);

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_COLLECT,
		MODE_SYNC
	} mode_t;

	mode_t                 mode_q;
	logic [4:0]            cnt_q;
	logic [7:0]            buf_q [FRAME_LEN];
	logic [TIME_WIDTH-1:0] last_q;

	logic                  accept;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] dt;
	logic                  timeout;
	logic                  gap_ok;
	logic                  hunting;
	logic                  complete;
	logic [4:0]            widx;
	logic [7:0]            byte0;
	logic                  start_ok;
	logic                  clear_b0;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign now_t    = TIME_WIDTH'(now_us);
	assign dt       = now_t - last_q;
	assign timeout  = !(dt < TIME_WIDTH'(failsafe_us));
	assign gap_ok   = dt > TIME_WIDTH'(sync_gap_us);
	assign hunting  = (mode_q != MODE_COLLECT) && (mode_q != MODE_SYNC);

	always_comb begin
		unique case (mode_q)
			MODE_COLLECT: begin
				widx     = cnt_q + 5'd1;
				complete = (cnt_q == 5'(FRAME_LEN - 2));
			end
			MODE_SYNC: begin
				widx     = cnt_q;
				complete = (cnt_q == 5'(FRAME_LEN - 1));
			end
			default: begin
				widx     = 5'd0;
				complete = 1'b1;
			end
		endcase
	end

	// While hunting the start byte is the one arriving now; otherwise it is already stored.
	assign byte0    = hunting ? rx_byte : buf_q[0];
	assign start_ok = (byte0 == START_BYTE);

	// Byte 0 survives a completed chunk only when a start byte is found while hunting.
	assign clear_b0 = complete && (timeout || !hunting || !(gap_ok && start_ok));

	assign push = accept && !rx_error && complete && (timeout || (!hunting && start_ok));

	// At completion the current byte lands in byte 0 or 24, so the snapshot is the stored bytes.
	always_comb begin
		for (int i = 0; i < ANALOG_BYTES; i++) begin
			push_entry.analog[8*i +: 8] = buf_q[i+1];
		end
		push_entry.flags = buf_q[FLAG_BYTE];
		push_entry.lost  = timeout || ((buf_q[FLAG_BYTE] & (BIT_LOSS | BIT_FAIL)) != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			cnt_q  <= 5'd0;
			last_q <= '0;
			for (int i = 0; i < FRAME_LEN; i++) begin
				buf_q[i] <= 8'd0;
			end
		end else if (accept) begin
			if (rx_error) begin
				mode_q   <= MODE_HUNT;
				cnt_q    <= 5'd0;
				buf_q[0] <= 8'd0;
			end else begin
				if (!(clear_b0 && (widx == 5'd0))) begin
					buf_q[widx] <= rx_byte;
				end
				if (clear_b0) begin
					buf_q[0] <= 8'd0;
				end
				if (!complete) begin
					cnt_q <= cnt_q + 5'd1;
				end else begin
					cnt_q  <= 5'd0;
					last_q <= now_t;
					if (timeout) begin
						mode_q <= MODE_HUNT;
					end else if (!hunting) begin
						mode_q <= start_ok ? MODE_SYNC : MODE_HUNT;
					end else if (gap_ok && start_ok) begin
						mode_q <= MODE_COLLECT;
					end else begin
						mode_q <= MODE_HUNT;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/sbusr_fifo.sv =====
module sbusr_fifo
	import sbusr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output frame_entry_t pop_entry,
	output logic         empty
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	frame_entry_t    mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntW'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sbusr_back.sv =====
module sbusr_back
	import sbusr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         queue_empty,
	input  frame_entry_t queue_entry,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [4:0]   chan_index,
	output logic [10:0]  chan_value,
	output logic         signal_lost,
	output logic         last_of_frame
);

	logic                   busy_q;
	logic [4:0]             k_q;
	logic [ANALOG_BITS-1:0] sh_q;
	logic [7:0]             flags_q;
	logic                   lost_q;
	logic                   out_valid_q;

	logic                   adv;
	logic                   last_k;
	logic [10:0]            val;

	assign adv    = busy_q && (!out_valid_q || out_ready);
	assign last_k = (k_q == 5'(CHAN_COUNT - 1));
	assign pop    = !queue_empty && (!busy_q || (adv && last_k));

	always_comb begin
		if (k_q < 5'(ANALOG_CHANS)) begin
			val = sh_q[CHAN_BITS-1:0];
		end else if (last_k) begin
			val = ((flags_q & BIT_CH18) != 8'd0) ? DIG_HIGH : DIG_LOW;
		end else begin
			val = ((flags_q & BIT_CH17) != 8'd0) ? DIG_HIGH : DIG_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q    <= queue_entry.analog;
			flags_q <= queue_entry.flags;
			lost_q  <= queue_entry.lost;
		end else if (adv) begin
			sh_q <= sh_q >> CHAN_BITS;
		end
		if (adv) begin
			chan_index    <= k_q;
			chan_value    <= val;
			signal_lost   <= lost_q;
			last_of_frame <= last_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 5'd0;
			end else if (adv) begin
				if (last_k) begin
					busy_q <= 1'b0;
				end
				k_q <= k_q + 5'd1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sbus_frame_receiver.sv =====
// SBUS frame receiver. Each transfer on the input channel is one UART byte with its
// microsecond timestamp and receive-error flag; a byte is taken every clock cycle
// unless the frame queue is full. A completed good frame, or any completed chunk after
// a gap of failsafe_us or more, produces 18 channel transfers on the output channel,
// one per cycle while out_ready is high, with last_of_frame marking channel 17. The
// back end emits a frame's channels one after another; a two-frame queue between the
// byte decoder and the channel emitter absorbs that burst, so input stalls only when two
// frames are already waiting. Registers sit at byte address 0 (sync_gap_us) and 4
// (failsafe_us); address bits below bit 2 are ignored.
module sbus_frame_receiver
	import sbusr_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_us,
	input  logic        rx_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  chan_index,
	output logic [10:0] chan_value,
	output logic        signal_lost,
	output logic        last_of_frame
);

	logic [31:0]  sync_gap_q;
	logic [31:0]  failsafe_q;
	logic         wr_en;
	logic [2:0]   reg_addr;

	logic         push;
	frame_entry_t push_entry;
	logic         queue_full;
	logic         pop;
	frame_entry_t pop_entry;
	logic         queue_empty;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign reg_addr = {paddr[2], 2'b00};

	always_comb begin
		unique case (reg_addr)
			ADDR_FAILSAFE: prdata = failsafe_q;
			default:       prdata = sync_gap_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_q <= SYNC_GAP_RESET;
			failsafe_q <= FAILSAFE_RESET;
		end else if (wr_en) begin
			unique case (reg_addr)
				ADDR_FAILSAFE: failsafe_q <= pwdata;
				default:       sync_gap_q <= pwdata;
			endcase
		end
	end

	sbusr_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.now_us     (now_us),
		.rx_error   (rx_error),
		.sync_gap_us(sync_gap_q),
		.failsafe_us(failsafe_q),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (queue_full)
	);

	sbusr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (queue_empty)
	);

	sbusr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.queue_entry  (pop_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chan_index   (chan_index),
		.chan_value   (chan_value),
		.signal_lost  (signal_lost),
		.last_of_frame(last_of_frame)
	);

endmodule
